FILE: hdl/cpl_pkg.sv
package cpl_pkg;

    localparam int CPL_COORD_WIDTH = 32;
    // width of one operand slice in the multipliers
    localparam int CPL_MUL_CHUNK = 32;

    typedef struct packed {
        logic par;
        logic deg;
    } cpl_flags_t;

    function automatic int cpl_chunks(input int w);
        return (w + CPL_MUL_CHUNK - 1) / CPL_MUL_CHUNK;
    endfunction

    function automatic int cpl_mul_lat(input int wa, input int wb);
        return cpl_chunks(wa) * cpl_chunks(wb) + 2;
    endfunction

    function automatic int cpl_div_lat(input int qw);
        return qw + 3;
    endfunction

endpackage

FILE: hdl/closest_points_two_lines.sv
// Closest points between two 3D lines in signed fixed point. One line pair is
// accepted per clock while the pipeline is not stalled, and results come out in
// order. Intermediate widths are D = 2W+3, E = 2D+1 and T = D+E+1, where W is
// COORD_WIDTH; the multipliers are sliced into 32-bit chunks and the dividers
// produce one quotient bit per stage. All stages advance together whenever the
// output register is empty or being taken, and in_ready is high exactly then.
module closest_points_two_lines #(
    parameter int COORD_WIDTH = cpl_pkg::CPL_COORD_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] first_point_x,
    input  logic signed [COORD_WIDTH-1:0] first_point_y,
    input  logic signed [COORD_WIDTH-1:0] first_point_z,
    input  logic signed [COORD_WIDTH-1:0] first_dir_x,
    input  logic signed [COORD_WIDTH-1:0] first_dir_y,
    input  logic signed [COORD_WIDTH-1:0] first_dir_z,
    input  logic signed [COORD_WIDTH-1:0] second_point_x,
    input  logic signed [COORD_WIDTH-1:0] second_point_y,
    input  logic signed [COORD_WIDTH-1:0] second_point_z,
    input  logic signed [COORD_WIDTH-1:0] second_dir_x,
    input  logic signed [COORD_WIDTH-1:0] second_dir_y,
    input  logic signed [COORD_WIDTH-1:0] second_dir_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] near_first_x,
    output logic signed [COORD_WIDTH-1:0] near_first_y,
    output logic signed [COORD_WIDTH-1:0] near_first_z,
    output logic signed [COORD_WIDTH-1:0] near_second_x,
    output logic signed [COORD_WIDTH-1:0] near_second_y,
    output logic signed [COORD_WIDTH-1:0] near_second_z,
    output logic                          lines_parallel,
    output logic                          second_degenerate,
    output logic                          result_saturated
);

    import cpl_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = 2 * W + 3;
    localparam int EW = 2 * DW + 1;
    localparam int TW = DW + EW + 1;
    localparam int NW = W + TW;
    localparam int L1 = cpl_mul_lat(W, W + 1);
    localparam int L2 = cpl_mul_lat(DW, DW);
    localparam int L3 = cpl_mul_lat(DW, EW);
    localparam int L4 = cpl_mul_lat(W, TW);
    localparam int LD = cpl_div_lat(W);
    localparam int D4 = L1 + L2 + L3 + 3;
    localparam int LT = D4 + L4 + LD + 2;

    function automatic logic [W:0] place(input logic signed [W-1:0] base,
                                         input logic [W-1:0] q,
                                         input logic neg,
                                         input logic big,
                                         input logic use_div);
        logic signed [W+1:0] hi, lo, sq, sum;
        logic [W:0] res;
        hi  = (W+2)'({1'b0, {(W-1){1'b1}}});
        lo  = ~hi;
        sq  = (W+2)'(q);
        sum = (W+2)'(base) + (neg ? -sq : sq);
        if (!use_div)
            res = {1'b0, base};
        else if (big)
            res = {1'b1, neg ? lo[W-1:0] : hi[W-1:0]};
        else if (sum > hi)
            res = {1'b1, hi[W-1:0]};
        else if (sum < lo)
            res = {1'b1, lo[W-1:0]};
        else
            res = {1'b0, sum[W-1:0]};
        return res;
    endfunction

    logic          en;
    logic [LT-1:0] vld_reg;

    assign en        = !vld_reg[LT-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[LT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LT-2:0], in_valid};
    end

    // input stage
    logic signed [W-1:0] p1_reg [3];
    logic signed [W-1:0] d1_reg [3];
    logic signed [W-1:0] p2_reg [3];
    logic signed [W-1:0] d2_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg[0] <= first_point_x;
            p1_reg[1] <= first_point_y;
            p1_reg[2] <= first_point_z;
            d1_reg[0] <= first_dir_x;
            d1_reg[1] <= first_dir_y;
            d1_reg[2] <= first_dir_z;
            p2_reg[0] <= second_point_x;
            p2_reg[1] <= second_point_y;
            p2_reg[2] <= second_point_z;
            d2_reg[0] <= second_dir_x;
            d2_reg[1] <= second_dir_y;
            d2_reg[2] <= second_dir_z;
        end
    end

    // dot product terms
    logic signed [W:0]   r_c  [3];
    logic signed [W:0]   d1_e [3];
    logic signed [W:0]   d2_e [3];
    logic signed [2*W:0] pa [3];
    logic signed [2*W:0] pb [3];
    logic signed [2*W:0] pc [3];
    logic signed [2*W:0] pe [3];
    logic signed [2*W:0] pf [3];

    for (genvar k = 0; k < 3; k++)
    begin : g_dot
        assign r_c[k]  = (W+1)'(p1_reg[k]) - (W+1)'(p2_reg[k]);
        assign d1_e[k] = (W+1)'(d1_reg[k]);
        assign d2_e[k] = (W+1)'(d2_reg[k]);

        cpl_mul #(.A_WIDTH(W), .B_WIDTH(W + 1)) u_aa
            (.clk(clk), .en(en), .a(d1_reg[k]), .b(d1_e[k]), .p(pa[k]));
        cpl_mul #(.A_WIDTH(W), .B_WIDTH(W + 1)) u_bb
            (.clk(clk), .en(en), .a(d1_reg[k]), .b(d2_e[k]), .p(pb[k]));
        cpl_mul #(.A_WIDTH(W), .B_WIDTH(W + 1)) u_cc
            (.clk(clk), .en(en), .a(d1_reg[k]), .b(r_c[k]), .p(pc[k]));
        cpl_mul #(.A_WIDTH(W), .B_WIDTH(W + 1)) u_ee
            (.clk(clk), .en(en), .a(d2_reg[k]), .b(d2_e[k]), .p(pe[k]));
        cpl_mul #(.A_WIDTH(W), .B_WIDTH(W + 1)) u_ff
            (.clk(clk), .en(en), .a(d2_reg[k]), .b(r_c[k]), .p(pf[k]));
    end

    logic signed [DW-1:0] a1_reg, b1_reg, c1_reg, e1_reg, f1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg <= DW'(pa[0]) + DW'(pa[1]) + DW'(pa[2]);
            b1_reg <= DW'(pb[0]) + DW'(pb[1]) + DW'(pb[2]);
            c1_reg <= DW'(pc[0]) + DW'(pc[1]) + DW'(pc[2]);
            e1_reg <= DW'(pe[0]) + DW'(pe[1]) + DW'(pe[2]);
            f1_reg <= DW'(pf[0]) + DW'(pf[1]) + DW'(pf[2]);
        end
    end

    // determinant and numerator of s
    logic signed [2*DW-1:0] ae, bb, bf, ce;

    cpl_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_ae
        (.clk(clk), .en(en), .a(a1_reg), .b(e1_reg), .p(ae));
    cpl_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_bb2
        (.clk(clk), .en(en), .a(b1_reg), .b(b1_reg), .p(bb));
    cpl_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_bf
        (.clk(clk), .en(en), .a(b1_reg), .b(f1_reg), .p(bf));
    cpl_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_ce
        (.clk(clk), .en(en), .a(c1_reg), .b(e1_reg), .p(ce));

    logic [3*DW-1:0]      dly1_out;
    logic signed [DW-1:0] b1_d, e1_d, f1_d;

    cpl_dly #(.WIDTH(3 * DW), .DEPTH(L2)) u_dly1
        (.clk(clk), .en(en), .din({b1_reg, e1_reg, f1_reg}), .dout(dly1_out));

    assign b1_d = dly1_out[3*DW-1:2*DW];
    assign e1_d = dly1_out[2*DW-1:DW];
    assign f1_d = dly1_out[DW-1:0];

    logic signed [EW-1:0] denom_c;
    logic signed [EW-1:0] denom2_reg, snum2_reg;
    logic signed [DW-1:0] b2_reg, e2_reg, f2_reg;
    cpl_flags_t           flags2_reg;

    assign denom_c = EW'(ae) - EW'(bb);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            denom2_reg     <= denom_c;
            snum2_reg      <= EW'(bf) - EW'(ce);
            b2_reg         <= b1_d;
            e2_reg         <= e1_d;
            f2_reg         <= f1_d;
            flags2_reg.par <= denom_c == '0;
            flags2_reg.deg <= e1_d == '0;
        end
    end

    // numerator and denominator of t
    logic signed [DW+EW-1:0] bs, fd, de;

    cpl_mul #(.A_WIDTH(DW), .B_WIDTH(EW)) u_bs
        (.clk(clk), .en(en), .a(b2_reg), .b(snum2_reg), .p(bs));
    cpl_mul #(.A_WIDTH(DW), .B_WIDTH(EW)) u_fd
        (.clk(clk), .en(en), .a(f2_reg), .b(denom2_reg), .p(fd));
    cpl_mul #(.A_WIDTH(DW), .B_WIDTH(EW)) u_de
        (.clk(clk), .en(en), .a(e2_reg), .b(denom2_reg), .p(de));

    localparam int D2W = 2 * EW + 2 * DW + 2;

    logic [D2W-1:0]       dly2_out;
    logic signed [EW-1:0] denom_d, snum_d;
    logic signed [DW-1:0] e2_d, f2_d;
    cpl_flags_t           flags2_d;

    cpl_dly #(.WIDTH(D2W), .DEPTH(L3)) u_dly2
        (.clk(clk), .en(en),
         .din({denom2_reg, snum2_reg, e2_reg, f2_reg, flags2_reg}), .dout(dly2_out));

    assign denom_d  = dly2_out[D2W-1 -: EW];
    assign snum_d   = dly2_out[D2W-1-EW -: EW];
    assign e2_d     = dly2_out[2*DW+1 -: DW];
    assign f2_d     = dly2_out[DW+1 -: DW];
    assign flags2_d = dly2_out[1:0];

    logic signed [TW-1:0] tnum3_reg, tden3_reg, snum3_reg, denom3_reg;
    cpl_flags_t           flags3_reg;

    // parallel lines: t = f / e
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tnum3_reg  <= flags2_d.par ? TW'(f2_d) : TW'(bs) + TW'(fd);
            tden3_reg  <= flags2_d.par ? TW'(e2_d) : TW'(de);
            snum3_reg  <= TW'(snum_d);
            denom3_reg <= TW'(denom_d);
            flags3_reg <= flags2_d;
        end
    end

    // directions held until the final products
    logic [6*W-1:0]      dir_d;
    logic signed [W-1:0] d1_d [3];
    logic signed [W-1:0] d2_d [3];

    cpl_dly #(.WIDTH(6 * W), .DEPTH(D4)) u_dly_dir
        (.clk(clk), .en(en),
         .din({d1_reg[0], d1_reg[1], d1_reg[2], d2_reg[0], d2_reg[1], d2_reg[2]}),
         .dout(dir_d));

    logic [2*TW-1:0]      dly3_out;
    logic signed [TW-1:0] den1_d, den2_d;
    cpl_flags_t           flags_d;

    cpl_dly #(.WIDTH(2 * TW), .DEPTH(L4)) u_dly3
        (.clk(clk), .en(en), .din({denom3_reg, tden3_reg}), .dout(dly3_out));

    assign den1_d = dly3_out[2*TW-1:TW];
    assign den2_d = dly3_out[TW-1:0];

    cpl_dly #(.WIDTH($bits(cpl_flags_t)), .DEPTH(L4 + LD)) u_dly_flags
        (.clk(clk), .en(en), .din(flags3_reg), .dout(flags_d));

    logic [6*W-1:0]      base_d;
    logic signed [W-1:0] base1 [3];
    logic signed [W-1:0] base2 [3];

    cpl_dly #(.WIDTH(6 * W), .DEPTH(D4 + L4 + LD)) u_dly_base
        (.clk(clk), .en(en),
         .din({p1_reg[0], p1_reg[1], p1_reg[2], p2_reg[0], p2_reg[1], p2_reg[2]}),
         .dout(base_d));

    logic signed [NW-1:0] pn1 [3];
    logic signed [NW-1:0] pn2 [3];
    logic [W-1:0]         q1 [3];
    logic [W-1:0]         q2 [3];
    logic                 neg1 [3];
    logic                 neg2 [3];
    logic                 big1 [3];
    logic                 big2 [3];

    for (genvar k = 0; k < 3; k++)
    begin : g_coord
        assign d1_d[k]  = dir_d[(5-k)*W +: W];
        assign d2_d[k]  = dir_d[(2-k)*W +: W];
        assign base1[k] = base_d[(5-k)*W +: W];
        assign base2[k] = base_d[(2-k)*W +: W];

        cpl_mul #(.A_WIDTH(W), .B_WIDTH(TW)) u_m1
            (.clk(clk), .en(en), .a(d1_d[k]), .b(snum3_reg), .p(pn1[k]));
        cpl_mul #(.A_WIDTH(W), .B_WIDTH(TW)) u_m2
            (.clk(clk), .en(en), .a(d2_d[k]), .b(tnum3_reg), .p(pn2[k]));

        cpl_div #(.N_WIDTH(NW), .D_WIDTH(TW), .Q_WIDTH(W)) u_div1
            (.clk(clk), .en(en), .n(pn1[k]), .d(den1_d),
             .q(q1[k]), .neg(neg1[k]), .big(big1[k]));
        cpl_div #(.N_WIDTH(NW), .D_WIDTH(TW), .Q_WIDTH(W)) u_div2
            (.clk(clk), .en(en), .n(pn2[k]), .d(den2_d),
             .q(q2[k]), .neg(neg2[k]), .big(big2[k]));
    end

    // add, clamp and register the result word
    logic [W:0]          pl1 [3];
    logic [W:0]          pl2 [3];
    logic signed [W-1:0] nf_reg [3];
    logic signed [W-1:0] ns_reg [3];
    logic                par_reg, deg_reg, sat_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pl1[k] = place(base1[k], q1[k], neg1[k], big1[k], !flags_d.par);
            pl2[k] = place(base2[k], q2[k], neg2[k], big2[k], !flags_d.deg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                nf_reg[k] <= pl1[k][W-1:0];
                ns_reg[k] <= pl2[k][W-1:0];
            end
            par_reg <= flags_d.par;
            deg_reg <= flags_d.deg;
            sat_reg <= pl1[0][W] | pl1[1][W] | pl1[2][W] | pl2[0][W] | pl2[1][W] | pl2[2][W];
        end
    end

    assign near_first_x      = nf_reg[0];
    assign near_first_y      = nf_reg[1];
    assign near_first_z      = nf_reg[2];
    assign near_second_x     = ns_reg[0];
    assign near_second_y     = ns_reg[1];
    assign near_second_z     = ns_reg[2];
    assign lines_parallel    = par_reg;
    assign second_degenerate = deg_reg;
    assign result_saturated  = sat_reg;

endmodule

FILE: hdl/cpl_dly.sv
module cpl_dly #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

FILE: hdl/cpl_mul.sv
module cpl_mul #(
    parameter int A_WIDTH = 32,
    parameter int B_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [A_WIDTH-1:0]         a,
    input  logic signed [B_WIDTH-1:0]         b,
    output logic signed [A_WIDTH+B_WIDTH-1:0] p
);

    import cpl_pkg::*;

    localparam int C  = CPL_MUL_CHUNK;
    localparam int NA = cpl_chunks(A_WIDTH);
    localparam int NB = cpl_chunks(B_WIDTH);
    localparam int K  = NA * NB;
    localparam int AW = NA * C;
    localparam int BW = NB * C;
    localparam int PW = A_WIDTH + B_WIDTH;
    localparam int XW = AW + BW;

    logic [A_WIDTH-1:0] a_u, abs_a;
    logic [B_WIDTH-1:0] b_u, abs_b;

    logic [AW-1:0] ua_reg  [K+1];
    logic [BW-1:0] ub_reg  [K+1];
    logic [PW-1:0] acc_reg [K+1];
    logic          neg_reg [K+1];
    logic signed [PW-1:0] p_reg;

    assign a_u   = a;
    assign b_u   = b;
    assign abs_a = a_u[A_WIDTH-1] ? (~a_u + 1'b1) : a_u;
    assign abs_b = b_u[B_WIDTH-1] ? (~b_u + 1'b1) : b_u;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg[0]  <= AW'(abs_a);
            ub_reg[0]  <= BW'(abs_b);
            acc_reg[0] <= '0;
            neg_reg[0] <= a_u[A_WIDTH-1] ^ b_u[B_WIDTH-1];
        end
    end

    // one slice pair per stage, accumulated on magnitudes
    for (genvar k = 0; k < K; k++)
    begin : g_pp
        localparam int I = k / NB;
        localparam int J = k % NB;
        logic [2*C-1:0] pp;
        logic [XW-1:0]  term;

        assign pp   = ua_reg[k][I*C +: C] * ub_reg[k][J*C +: C];
        assign term = XW'(pp) << ((I + J) * C);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ua_reg[k+1]  <= ua_reg[k];
                ub_reg[k+1]  <= ub_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                acc_reg[k+1] <= acc_reg[k] + term[PW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= neg_reg[K] ? (~acc_reg[K] + 1'b1) : acc_reg[K];
        end
    end

    assign p = p_reg;

endmodule

FILE: hdl/cpl_div.sv
module cpl_div #(
    parameter int N_WIDTH = 64,
    parameter int D_WIDTH = 32,
    parameter int Q_WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [N_WIDTH-1:0] n,
    input  logic signed [D_WIDTH-1:0] d,
    output logic        [Q_WIDTH-1:0] q,
    output logic                      neg,
    output logic                      big
);

    localparam int MW = (N_WIDTH > D_WIDTH) ? N_WIDTH : D_WIDTH;
    localparam int RW = MW + 2;
    localparam int XW = RW + Q_WIDTH + 1;

    logic [N_WIDTH-1:0] n_u, an;
    logic [D_WIDTH-1:0] d_u, ad;

    logic [N_WIDTH-1:0] an_reg;
    logic [D_WIDTH-1:0] ad_reg;
    logic               sa_reg;
    logic [RW-1:0]      n2_reg, d2_reg;
    logic               sb_reg;

    logic [RW-1:0]      rem_reg [Q_WIDTH+1];
    logic [RW-1:0]      d2s_reg [Q_WIDTH+1];
    logic [Q_WIDTH-1:0] quo_reg [Q_WIDTH+1];
    logic               neg_reg [Q_WIDTH+1];
    logic               big_reg [Q_WIDTH+1];

    assign n_u = n;
    assign d_u = d;
    assign an  = n_u[N_WIDTH-1] ? (~n_u + 1'b1) : n_u;
    assign ad  = d_u[D_WIDTH-1] ? (~d_u + 1'b1) : d_u;

    // round to nearest, ties away from zero: (2|n| + |d|) / (2|d|)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            an_reg <= an;
            ad_reg <= ad;
            sa_reg <= n_u[N_WIDTH-1] ^ d_u[D_WIDTH-1];
            n2_reg <= (RW'(an_reg) << 1) + RW'(ad_reg);
            d2_reg <= RW'(ad_reg) << 1;
            sb_reg <= sa_reg;
            rem_reg[0] <= n2_reg;
            d2s_reg[0] <= d2_reg;
            quo_reg[0] <= '0;
            neg_reg[0] <= sb_reg;
            // quotient too large for Q_WIDTH bits
            big_reg[0] <= XW'(n2_reg) >= (XW'(d2_reg) << Q_WIDTH);
        end
    end

    for (genvar i = 0; i < Q_WIDTH; i++)
    begin : g_step
        localparam int S = Q_WIDTH - 1 - i;
        logic [XW:0] diff;
        logic        ge;

        assign diff = {1'b0, XW'(rem_reg[i])} - {1'b0, (XW'(d2s_reg[i]) << S)};
        assign ge   = !diff[XW];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= ge ? diff[RW-1:0] : rem_reg[i];
                d2s_reg[i+1] <= d2s_reg[i];
                quo_reg[i+1] <= quo_reg[i] | (Q_WIDTH'(ge) << S);
                neg_reg[i+1] <= neg_reg[i];
                big_reg[i+1] <= big_reg[i];
            end
        end
    end

    assign q   = quo_reg[Q_WIDTH];
    assign neg = neg_reg[Q_WIDTH];
    assign big = big_reg[Q_WIDTH];

endmodule

FILE: hdl/cpl_chk.sv
module cpl_chk #(
    parameter int COORD_WIDTH = cpl_pkg::CPL_COORD_WIDTH
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [COORD_WIDTH-1:0] near_first_x,
    input logic signed [COORD_WIDTH-1:0] near_first_y,
    input logic signed [COORD_WIDTH-1:0] near_first_z,
    input logic signed [COORD_WIDTH-1:0] near_second_x,
    input logic signed [COORD_WIDTH-1:0] near_second_y,
    input logic signed [COORD_WIDTH-1:0] near_second_z,
    input logic                          lines_parallel,
    input logic                          second_degenerate,
    input logic                          result_saturated
);

    // a zero second direction always gives a zero determinant
    a_deg_par: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && second_degenerate |-> lines_parallel)
        else $error("degenerate word without parallel flag");

    // the pipeline moves whenever the output register can drain
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow output drain");

    // hold a stalled result word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({near_first_x, near_first_y, near_first_z,
                        near_second_x, near_second_y, near_second_z,
                        lines_parallel, second_degenerate, result_saturated}))
        else $error("stalled result word changed");

endmodule

bind closest_points_two_lines cpl_chk #(.COORD_WIDTH(COORD_WIDTH)) u_cpl_chk (.*);
